### rtl/assert_macros.svh
// Shared assertion macros for the decoder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define NEC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("decoder assertion failed");

// Expression must never be true outside reset.
`define NEC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `NEC_ASSERT(lbl, clk, rst_n, !(expr))

`endif

### rtl/nec_dec_pkg.sv
package nec_dec_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT0_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT1_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_START_TICKS = 16'd90;
  localparam logic [CFG_W-1:0] RST_REPEAT_GAP  = 16'd22;
  localparam logic [CFG_W-1:0] RST_FRAME_GAP   = 16'd45;
  localparam logic [CFG_W-1:0] RST_BIT0_TICKS  = 16'd11;
  localparam logic [CFG_W-1:0] RST_BIT1_TICKS  = 16'd22;
  localparam logic [CFG_W-1:0] RST_IDLE_LIMIT  = 16'd1200;

  // decoder phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_GAP      = 3'd2;
  localparam logic [2:0] PH_REPEAT   = 3'd3;
  localparam logic [2:0] PH_ADDR     = 3'd4;
  localparam logic [2:0] PH_ADDR_INV = 3'd5;
  localparam logic [2:0] PH_CMD      = 3'd6;
  localparam logic [2:0] PH_CMD_INV  = 3'd7;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [3:0] BITS_PER_B = 4'd8;

  localparam logic KIND_TICK = 1'b0;

  typedef struct packed {
    logic kind;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic       frame_done;
    logic       repeat_done;
    logic [7:0] address;
    logic [7:0] command;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_ticks;
    logic [CFG_W-1:0] repeat_gap_ticks;
    logic [CFG_W-1:0] frame_gap_ticks;
    logic [CFG_W-1:0] bit0_ticks;
    logic [CFG_W-1:0] bit1_ticks;
    logic [CFG_W-1:0] idle_limit_ticks;
  } cfg_t;

endpackage

### rtl/nec_dec_cfg.sv
module nec_dec_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nec_dec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nec_dec_pkg::CFG_W-1:0]     cfg_data_i,
  output nec_dec_pkg::cfg_t                 cfg_o
);

  nec_dec_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_ticks      <= nec_dec_pkg::RST_START_TICKS;
      cfg_q.repeat_gap_ticks <= nec_dec_pkg::RST_REPEAT_GAP;
      cfg_q.frame_gap_ticks  <= nec_dec_pkg::RST_FRAME_GAP;
      cfg_q.bit0_ticks       <= nec_dec_pkg::RST_BIT0_TICKS;
      cfg_q.bit1_ticks       <= nec_dec_pkg::RST_BIT1_TICKS;
      cfg_q.idle_limit_ticks <= nec_dec_pkg::RST_IDLE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nec_dec_pkg::REG_START_TICKS: cfg_q.start_ticks      <= cfg_data_i;
        nec_dec_pkg::REG_REPEAT_GAP:  cfg_q.repeat_gap_ticks <= cfg_data_i;
        nec_dec_pkg::REG_FRAME_GAP:   cfg_q.frame_gap_ticks  <= cfg_data_i;
        nec_dec_pkg::REG_BIT0_TICKS:  cfg_q.bit0_ticks       <= cfg_data_i;
        nec_dec_pkg::REG_BIT1_TICKS:  cfg_q.bit1_ticks       <= cfg_data_i;
        nec_dec_pkg::REG_IDLE_LIMIT:  cfg_q.idle_limit_ticks <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/nec_dec_engine.sv
module nec_dec_engine #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  nec_dec_pkg::in_item_t  item_i,
  input  nec_dec_pkg::cfg_t      cfg_i,
  output nec_dec_pkg::out_item_t result_o
);

  // compare width: holds the counter and nominal+1
  localparam int unsigned CMP_W = (COUNTER_WIDTH > 17) ? COUNTER_WIDTH : 17;

  logic [2:0]               phase_q,  phase_d;
  logic [COUNTER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                     parity_q, parity_d;
  logic [3:0]               bidx_q,   bidx_d;
  logic [7:0]               addr_q,   addr_d;
  logic [7:0]               addr_inv_q, addr_inv_d;
  logic [7:0]               cmd_q,    cmd_d;
  logic [7:0]               cmd_inv_q, cmd_inv_d;

  logic [COUNTER_WIDTH-1:0] elapsed_inc;
  logic [CMP_W-1:0]         elapsed_x;
  logic [3:0]               idx;
  logic [7:0]               tgt_old;
  logic [7:0]               tgt_new;
  logic                     full;
  logic                     frame_done, repeat_done;

  function automatic logic at_least(input logic [nec_dec_pkg::CFG_W-1:0] n,
                                    input logic [CMP_W-1:0] e);
    return (n == '0) || (e >= (CMP_W'(n) - CMP_W'(1)));
  endfunction

  function automatic logic in_window(input logic [nec_dec_pkg::CFG_W-1:0] n,
                                     input logic [CMP_W-1:0] e);
    return at_least(n, e) && (e <= (CMP_W'(n) + CMP_W'(1)));
  endfunction

  function automatic logic data_ok(input logic [7:0] a, input logic [7:0] ai,
                                   input logic [7:0] c, input logic [7:0] ci);
    return ((a ^ ai) == nec_dec_pkg::BYTE_ONES) && ((c ^ ci) == nec_dec_pkg::BYTE_ONES);
  endfunction

  assign elapsed_inc = elapsed_q + COUNTER_WIDTH'(1);
  assign elapsed_x   = CMP_W'(elapsed_q);

  // byte currently being filled
  always_comb begin
    case (phase_q)
      nec_dec_pkg::PH_ADDR:     tgt_old = addr_q;
      nec_dec_pkg::PH_ADDR_INV: tgt_old = addr_inv_q;
      nec_dec_pkg::PH_CMD:      tgt_old = cmd_q;
      default:                  tgt_old = cmd_inv_q;
    endcase
  end

  // bit decode on the closing edge of a bit period
  always_comb begin
    idx     = bidx_q;
    tgt_new = tgt_old;
    full    = 1'b0;
    if (in_window(cfg_i.bit0_ticks, elapsed_x)) begin
      idx = idx + 4'd1;
    end
    if (at_least(cfg_i.bit1_ticks, elapsed_x)) begin
      if (idx < nec_dec_pkg::BITS_PER_B) begin
        tgt_new = tgt_old | (8'd1 << idx[2:0]);
      end
      idx = idx + 4'd1;
    end
    if (idx >= nec_dec_pkg::BITS_PER_B) begin
      idx  = 4'd0;
      full = 1'b1;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    parity_d    = parity_q;
    bidx_d      = bidx_q;
    addr_d      = addr_q;
    addr_inv_d  = addr_inv_q;
    cmd_d       = cmd_q;
    cmd_inv_d   = cmd_inv_q;
    frame_done  = 1'b0;
    repeat_done = 1'b0;

    if (item_i.kind == nec_dec_pkg::KIND_TICK) begin
      if (CMP_W'(elapsed_inc) >= CMP_W'(cfg_i.idle_limit_ticks)) begin
        // idle timeout: full clear
        phase_d    = nec_dec_pkg::PH_IDLE;
        elapsed_d  = '0;
        parity_d   = 1'b0;
        bidx_d     = '0;
        addr_d     = '0;
        addr_inv_d = '0;
        cmd_d      = '0;
        cmd_inv_d  = '0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end else begin
      case (phase_q)
        nec_dec_pkg::PH_IDLE: begin
          if (!item_i.pin_level) begin
            phase_d = nec_dec_pkg::PH_START;
          end
          elapsed_d = '0;
        end
        nec_dec_pkg::PH_START: begin
          if (at_least(cfg_i.start_ticks, elapsed_x)) begin
            phase_d = nec_dec_pkg::PH_GAP;
          end
          elapsed_d = '0;
        end
        nec_dec_pkg::PH_GAP: begin
          if (in_window(cfg_i.repeat_gap_ticks, elapsed_x)) begin
            phase_d = nec_dec_pkg::PH_REPEAT;
          end else if (in_window(cfg_i.frame_gap_ticks, elapsed_x)) begin
            phase_d    = nec_dec_pkg::PH_ADDR;
            addr_d     = '0;
            addr_inv_d = '0;
            cmd_d      = '0;
            cmd_inv_d  = '0;
            parity_d   = 1'b0;
            bidx_d     = '0;
          end else begin
            phase_d = nec_dec_pkg::PH_IDLE;
          end
          elapsed_d = '0;
        end
        nec_dec_pkg::PH_REPEAT: begin
          repeat_done = data_ok(addr_q, addr_inv_q, cmd_q, cmd_inv_q);
          phase_d     = nec_dec_pkg::PH_IDLE;
          elapsed_d   = '0;
        end
        default: begin
          // data phases: odd edge only flips parity
          parity_d = ~parity_q;
          if (parity_q) begin
            bidx_d    = idx;
            elapsed_d = '0;
            case (phase_q)
              nec_dec_pkg::PH_ADDR: begin
                addr_d = tgt_new;
                if (full) phase_d = nec_dec_pkg::PH_ADDR_INV;
              end
              nec_dec_pkg::PH_ADDR_INV: begin
                addr_inv_d = tgt_new;
                if (full) phase_d = nec_dec_pkg::PH_CMD;
              end
              nec_dec_pkg::PH_CMD: begin
                cmd_d = tgt_new;
                if (full) phase_d = nec_dec_pkg::PH_CMD_INV;
              end
              default: begin
                cmd_inv_d = tgt_new;
                if (full) begin
                  frame_done = data_ok(addr_q, addr_inv_q, cmd_q, tgt_new);
                  phase_d    = nec_dec_pkg::PH_IDLE;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= nec_dec_pkg::PH_IDLE;
      elapsed_q  <= '0;
      parity_q   <= 1'b0;
      bidx_q     <= '0;
      addr_q     <= '0;
      addr_inv_q <= '0;
      cmd_q      <= '0;
      cmd_inv_q  <= '0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      parity_q   <= parity_d;
      bidx_q     <= bidx_d;
      addr_q     <= addr_d;
      addr_inv_q <= addr_inv_d;
      cmd_q      <= cmd_d;
      cmd_inv_q  <= cmd_inv_d;
    end
  end

  assign result_o.frame_done  = frame_done;
  assign result_o.repeat_done = repeat_done;
  assign result_o.address     = addr_d;
  assign result_o.command     = cmd_d;

endmodule

### rtl/nec_ir_frame_decoder_core.sv
// NEC infrared frame decoder.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction is
// either a timer tick (kind 0) or a receiver pin edge (kind 1, with the
// pin level). Output channel (out_valid_o / out_ready_i / out_data_o):
// exactly one transaction per input, in order, carrying the frame and
// repeat pulses plus the stored address and command bytes.
// Timing registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must do so only while no transaction is in flight (not enforced).
//
// An accepted input waits in the input register, and its result is shown
// from the result register. Throughput is one transaction per cycle while
// the output does not stall; the decode between the input register and
// the result register is a handful of compares, at least 17 bits wide, and one byte update.
// Reset clears the decoder state and loads the default timings; both
// pipeline registers come up empty. When the receiver stalls, the result
// holds in the output register and one more input is still taken into the
// input register; only then does in_ready_o drop.
module nec_ir_frame_decoder_core #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  nec_dec_pkg::in_item_t             in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output nec_dec_pkg::out_item_t            out_data_o,
  input  logic                              cfg_we_i,
  input  logic [nec_dec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nec_dec_pkg::CFG_W-1:0]     cfg_data_i
);

  nec_dec_pkg::cfg_t      cfg;
  nec_dec_pkg::in_item_t  in_q;
  nec_dec_pkg::out_item_t out_q;
  nec_dec_pkg::out_item_t result;
  logic                   in_valid_q;
  logic                   out_valid_q;
  logic                   advance;

  // input register moves to the result register when that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  nec_dec_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // decoder state commits only when the transaction moves on
  nec_dec_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/nec_dec_checker.sv
`include "assert_macros.svh"

module nec_dec_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input nec_dec_pkg::out_item_t out_data_o
);

  // a result transaction never reports a frame and a repeat together
  `NEC_ASSERT_NEVER(a_one_pulse, clk_i, rst_ni,
    out_valid_o && out_data_o.frame_done && out_data_o.repeat_done)

  // a stalled result stays put
  `NEC_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // the input side only backs up behind a stalled output
  `NEC_ASSERT(a_ready_backpressure, clk_i, rst_ni,
    !in_ready_o |-> out_valid_o && !out_ready_i)

  // an output appearing from empty comes from an input accepted earlier
  `NEC_ASSERT(a_out_source, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))

endmodule

bind nec_ir_frame_decoder_core nec_dec_checker u_nec_dec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

  // Edge transactions carry kind 1; ticks use the package code.
  localparam logic KIND_EDGE = ~nec_dec_pkg::KIND_TICK;
  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Length of the forced receiver hold-off.
  localparam int unsigned LONG_HOLD = 300;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  nec_dec_pkg::in_item_t             in_data_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  nec_dec_pkg::out_item_t            out_data_o;
  logic                              cfg_we_i = 1'b0;
  logic [nec_dec_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [nec_dec_pkg::CFG_W-1:0]     cfg_data_i = '0;

  nec_ir_frame_decoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder predictor: own copy of timing registers and decoder state.
  // ---------------------------------------------------------------------
  nec_dec_pkg::cfg_t dec_cfg;
  logic [2:0]        dec_phase;
  logic [15:0]       dec_elapsed;
  logic              dec_parity;
  logic [3:0]        dec_bit_pos;
  logic [7:0]        dec_addr, dec_addr_n, dec_cmd, dec_cmd_n;

  // Pending pin/timer events and decoder results still owed by the DUT.
  nec_dec_pkg::in_item_t  ir_events[$];
  nec_dec_pkg::out_item_t decoded_q[$];

  int unsigned issued_cnt = 0;   // events handed to the input channel
  int unsigned checked_cnt = 0;  // results compared
  int unsigned fail_cnt = 0;
  int unsigned frames_seen = 0, repeats_seen = 0;
  int unsigned frames_sent = 0, repeats_sent = 0;
  bit          tx_steady = 1'b0; // sender without gaps
  int unsigned hold_req = 0;     // bumped to ask for one long hold-off

  function automatic void dec_clear();
    dec_phase   = nec_dec_pkg::PH_IDLE;
    dec_elapsed = '0;
    dec_parity  = 1'b0;
    dec_bit_pos = '0;
    dec_addr    = '0;
    dec_addr_n  = '0;
    dec_cmd     = '0;
    dec_cmd_n   = '0;
  endfunction

  // elapsed >= nominal - 1; a nominal of 0 gives a bound of -1.
  function automatic bit reached(logic [15:0] nom);
    int e, n;
    e = dec_elapsed;
    n = nom;
    return e >= n - 1;
  endfunction

  function automatic bit in_win(logic [15:0] nom);
    int e, n;
    e = dec_elapsed;
    n = nom;
    return reached(nom) && (e <= n + 1);
  endfunction

  function automatic bit bytes_check();
    return ((dec_addr ^ dec_addr_n) == nec_dec_pkg::BYTE_ONES) &&
           ((dec_cmd ^ dec_cmd_n) == nec_dec_pkg::BYTE_ONES);
  endfunction

  // In a data phase the edges alternate between opening and closing a bit period; 1 when the byte fills.
  function automatic bit take_bit(inout logic [7:0] tgt);
    bit full;
    full = 1'b0;
    dec_parity = ~dec_parity;
    if (!dec_parity) begin
      // A period that lies in both windows counts a zero and then a one.
      if (in_win(dec_cfg.bit0_ticks)) dec_bit_pos = dec_bit_pos + 4'd1;
      if (reached(dec_cfg.bit1_ticks)) begin
        if (dec_bit_pos < nec_dec_pkg::BITS_PER_B) tgt = tgt | (8'd1 << dec_bit_pos);
        dec_bit_pos = dec_bit_pos + 4'd1;
      end
      if (dec_bit_pos >= nec_dec_pkg::BITS_PER_B) begin
        dec_bit_pos = '0;
        full = 1'b1;
      end
      dec_elapsed = '0;
    end
    return full;
  endfunction

  function automatic nec_dec_pkg::out_item_t nec_decode_step(nec_dec_pkg::in_item_t ev);
    nec_dec_pkg::out_item_t r;
    r = '0;
    if (ev.kind == nec_dec_pkg::KIND_TICK) begin
      dec_elapsed = dec_elapsed + 16'd1;
      if (dec_elapsed >= dec_cfg.idle_limit_ticks) dec_clear();
    end else begin
      case (dec_phase)
        nec_dec_pkg::PH_IDLE: begin
          if (!ev.pin_level) dec_phase = nec_dec_pkg::PH_START;
          dec_elapsed = '0;
        end
        nec_dec_pkg::PH_START: begin
          // short start pulse keeps waiting, count restarts
          if (reached(dec_cfg.start_ticks)) dec_phase = nec_dec_pkg::PH_GAP;
          dec_elapsed = '0;
        end
        nec_dec_pkg::PH_GAP: begin
          // repeat window wins over the frame window
          if (in_win(dec_cfg.repeat_gap_ticks)) begin
            dec_phase = nec_dec_pkg::PH_REPEAT;
          end else if (in_win(dec_cfg.frame_gap_ticks)) begin
            dec_phase   = nec_dec_pkg::PH_ADDR;
            dec_addr    = '0;
            dec_addr_n  = '0;
            dec_cmd     = '0;
            dec_cmd_n   = '0;
            dec_parity  = 1'b0;
            dec_bit_pos = '0;
          end else begin
            dec_phase = nec_dec_pkg::PH_IDLE;
          end
          dec_elapsed = '0;
        end
        nec_dec_pkg::PH_REPEAT: begin
          r.repeat_done = bytes_check();
          dec_phase     = nec_dec_pkg::PH_IDLE;
          dec_elapsed   = '0;
        end
        nec_dec_pkg::PH_ADDR:
          if (take_bit(dec_addr)) dec_phase = nec_dec_pkg::PH_ADDR_INV;
        nec_dec_pkg::PH_ADDR_INV:
          if (take_bit(dec_addr_n)) dec_phase = nec_dec_pkg::PH_CMD;
        nec_dec_pkg::PH_CMD:
          if (take_bit(dec_cmd)) dec_phase = nec_dec_pkg::PH_CMD_INV;
        default: begin
          if (take_bit(dec_cmd_n)) begin
            r.frame_done = bytes_check();
            dec_phase    = nec_dec_pkg::PH_IDLE;
          end
        end
      endcase
    end
    r.address = dec_addr;
    r.command = dec_cmd;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps between them unless tx_steady is set.
  // ---------------------------------------------------------------------
  int unsigned gap_left = 0, burst_left = 0;

  always @(posedge clk_i) begin : drv_proc
    logic vld;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      vld = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        decoded_q.push_back(nec_decode_step(in_data_i));
        vld = 1'b0;
      end
      if (!vld) begin
        if (gap_left > 0 && !tx_steady) begin
          gap_left--;
        end else if (ir_events.size() > 0) begin
          in_data_i <= ir_events.pop_front();
          issued_cnt++;
          vld = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= vld;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: rotating stall patterns, plus a long hold-off on request.
  // ---------------------------------------------------------------------
  int unsigned rx_cyc = 0, hold_left = 0, hold_served = 0;

  always @(posedge clk_i) begin : rx_proc
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cyc / 50) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ((rx_cyc % 5) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each result transaction against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : mon_proc
    nec_dec_pkg::out_item_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (decoded_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        fail_cnt++;
      end else begin
        want = decoded_q.pop_front();
        checked_cnt++;
        if (want.frame_done) frames_seen++;
        if (want.repeat_done) repeats_seen++;
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
          fail_cnt++;
        end
        if (got.repeat_done !== want.repeat_done) begin
          $error("repeat_done: expected %0d, actual %0d", want.repeat_done, got.repeat_done);
          fail_cnt++;
        end
        if (got.address !== want.address) begin
          $error("address: expected %02h, actual %02h", want.address, got.address);
          fail_cnt++;
        end
        if (got.command !== want.command) begin
          $error("command: expected %02h, actual %02h", want.command, got.command);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  int unsigned cyc = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic nec_dec_pkg::cfg_t mk_timing(int st, int rg, int fg, int b0, int b1,
                                                  int il);
    nec_dec_pkg::cfg_t c;
    c.start_ticks      = nec_dec_pkg::CFG_W'(st);
    c.repeat_gap_ticks = nec_dec_pkg::CFG_W'(rg);
    c.frame_gap_ticks  = nec_dec_pkg::CFG_W'(fg);
    c.bit0_ticks       = nec_dec_pkg::CFG_W'(b0);
    c.bit1_ticks       = nec_dec_pkg::CFG_W'(b1);
    c.idle_limit_ticks = nec_dec_pkg::CFG_W'(il);
    return c;
  endfunction

  task automatic write_reg(logic [nec_dec_pkg::CFG_IDX_W-1:0] idx,
                           logic [nec_dec_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_timing(nec_dec_pkg::cfg_t c);
    write_reg(nec_dec_pkg::REG_START_TICKS, c.start_ticks);
    write_reg(nec_dec_pkg::REG_REPEAT_GAP, c.repeat_gap_ticks);
    write_reg(nec_dec_pkg::REG_FRAME_GAP, c.frame_gap_ticks);
    write_reg(nec_dec_pkg::REG_BIT0_TICKS, c.bit0_ticks);
    write_reg(nec_dec_pkg::REG_BIT1_TICKS, c.bit1_ticks);
    write_reg(nec_dec_pkg::REG_IDLE_LIMIT, c.idle_limit_ticks);
    dec_cfg = c;
  endtask

  // Every issued transaction answered; then a pause for pipeline slack.
  task automatic wait_drained();
    while (ir_events.size() != 0 || issued_cnt != checked_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_ev(logic k, logic lvl);
    nec_dec_pkg::in_item_t ev;
    ev.kind      = k;
    ev.pin_level = lvl;
    ir_events.push_back(ev);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_ev(nec_dec_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_edge(logic lvl);
    push_ev(KIND_EDGE, lvl);
  endtask

  task automatic push_noise(int n);
    repeat (n) push_ev(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // nominal with +-1 jitter, never negative
  function automatic int jitter(int nom);
    int v;
    v = nom + $urandom_range(0, 2) - 1;
    return (v < 0) ? 0 : v;
  endfunction

  // falling edge, start pulse, gap of the given length
  task automatic push_header(int gap);
    push_edge(1'b0);
    push_ticks(dec_cfg.start_ticks + $urandom_range(0, 1));
    push_edge(1'($urandom_range(0, 1)));
    push_ticks(gap);
    push_edge(1'($urandom_range(0, 1)));
  endtask

  // Full or truncated frame; now and then one bit of the word is flipped.
  task automatic push_frame(bit broken);
    logic [31:0] word;
    logic [7:0]  ad, cm;
    int          cut, per, a;
    ad   = 8'($urandom);
    cm   = 8'($urandom);
    word = {~cm, cm, ~ad, ad};
    if ($urandom_range(0, 5) == 0) word[$urandom_range(0, 31)] ^= 1'b1;
    cut = broken ? $urandom_range(0, 31) : 32;
    push_header(jitter(dec_cfg.frame_gap_ticks));
    for (int b = 0; b < cut; b++) begin
      per = word[b] ? dec_cfg.bit1_ticks + $urandom_range(0, 1) : jitter(dec_cfg.bit0_ticks);
      a   = $urandom_range(0, per);
      push_ticks(a);
      push_edge(1'($urandom_range(0, 1)));
      push_ticks(per - a);
      push_edge(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic push_repeat();
    push_header(jitter(dec_cfg.repeat_gap_ticks));
    push_ticks($urandom_range(0, 3));
    push_edge(1'($urandom_range(0, 1)));
  endtask

  task automatic push_seq(bit noise_only);
    int pick;
    pick = noise_only ? 99 : $urandom_range(0, 99);
    if (pick < 50) begin
      push_frame(1'b0);
      frames_sent++;
    end else if (pick < 70) begin
      push_repeat();
      repeats_sent++;
    end else begin
      if (pick < 82) push_frame(1'b1);
      else push_noise($urandom_range(3, 20));
      // with an idle limit of at most 400 ticks, a quiet spell long enough to clear the decoder before the next frame
      if (dec_cfg.idle_limit_ticks <= 400)
        push_ticks(dec_cfg.idle_limit_ticks + $urandom_range(0, 2));
    end
  endtask

  // One timing setup: first half, full drain (sender pauses, optional receiver hold-off), second half.
  task automatic run_phase(nec_dec_pkg::cfg_t c, int nseq, bit noise_only, bit with_hold);
    load_timing(c);
    for (int i = 0; i < nseq; i++) begin
      if (i == nseq / 2) begin
        if (with_hold) hold_req++;
        wait_drained();
      end
      push_seq(noise_only);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin : stim
    nec_dec_pkg::cfg_t basic;
    dec_cfg = '{nec_dec_pkg::RST_START_TICKS, nec_dec_pkg::RST_REPEAT_GAP,
                nec_dec_pkg::RST_FRAME_GAP, nec_dec_pkg::RST_BIT0_TICKS,
                nec_dec_pkg::RST_BIT1_TICKS, nec_dec_pkg::RST_IDLE_LIMIT};
    dec_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small timings: repeat gap 2..4, frame gap 5..7, zero 0..2, one >= 3.
    basic = mk_timing(2, 3, 6, 1, 4, 60);
    load_timing(basic);

    // Directed: high edge in idle, short start pulse, repeat with unchecked
    // data, and a gap that fits neither window.
    push_edge(1'b1);
    push_ticks(1);
    push_edge(1'b0);
    push_edge(1'b1);
    push_ticks(2);
    push_edge(1'b0);
    push_ticks(3);
    push_edge(1'b1);
    push_edge(1'b0);
    push_edge(1'b0);
    push_ticks(1);
    push_edge(1'b1);
    push_edge(1'b1);
    wait_drained();

    run_phase(basic, 3, 1'b0, 1'b1);
    // overlapping zero and one windows, back-to-back transactions
    tx_steady = 1'b1;
    run_phase(mk_timing(1, 2, 5, 2, 2, 80), 1, 1'b0, 1'b0);
    tx_steady = 1'b0;
    // lowest values: every tick clears the decoder
    run_phase(mk_timing(1, 1, 1, 1, 1, 1), 1, 1'b0, 1'b0);
    // highest values: the start pulse never completes
    run_phase(mk_timing(65535, 65535, 65535, 65535, 65535, 65535), 2, 1'b1, 1'b0);
    // default timings, short noise bursts only
    run_phase(mk_timing(nec_dec_pkg::RST_START_TICKS, nec_dec_pkg::RST_REPEAT_GAP,
                        nec_dec_pkg::RST_FRAME_GAP, nec_dec_pkg::RST_BIT0_TICKS,
                        nec_dec_pkg::RST_BIT1_TICKS, nec_dec_pkg::RST_IDLE_LIMIT),
              1, 1'b1, 1'b0);
    repeat (2) begin
      basic = mk_timing($urandom_range(1, 6), $urandom_range(1, 4), 0,
                        $urandom_range(1, 3), 0, $urandom_range(30, 120));
      basic.frame_gap_ticks = nec_dec_pkg::CFG_W'(basic.repeat_gap_ticks +
                                                   $urandom_range(3, 6));
      basic.bit1_ticks      = nec_dec_pkg::CFG_W'(basic.bit0_ticks + $urandom_range(0, 3));
      run_phase(basic, 1, 1'b0, 1'b0);
    end

    repeat (16) @(posedge clk_i);
    $display("Run covered %0d transactions over seven timing setups", checked_cnt);
    $display("  %0d frames and %0d repeats offered, %0d frames and %0d repeats decoded",
             frames_sent, repeats_sent, frames_seen, repeats_seen);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
